>>> src/lcrm_pkg.sv
// ----------------------------------------------------------------------------
// lcrm_pkg: shared definitions for the low complexity run masker
// Defaults, register indexes, fill letters, the result word and case helpers.
// ----------------------------------------------------------------------------
package lcrm_pkg;

   localparam int WINDOW_DEF   = 8;
   localparam int POS_BITS_DEF = 20;
   localparam int HOMO_MIN_DEF = 5;
   localparam int PAIR_MIN_DEF = 5;

   localparam int COUNT_BITS = 22;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = 22'h3F_FFFF;

   // mark requests raised per word: pair of the other phase, closed pair, letter run
   localparam int NUM_MARKS = 3;

   localparam int SOFT_OFFSET   = 2;
   localparam int HARD_OFFSET   = 1;
   localparam int LETTER_OFFSET = 2;

   localparam logic [7:0] FILL_NUCLEO  = 8'h4E;   // 'N'
   localparam logic [7:0] FILL_PROTEIN = 8'h58;   // 'X'

   localparam int CSR_DATA_BITS  = 1;
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HARD_MASK   = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUCLEO_MODE = 1'b1;

   typedef struct packed {
      logic [7:0]            char_out;
      logic                  seq_end;
      logic [COUNT_BITS-1:0] masked_count;
   } out_word_type;

   function automatic logic [7:0] up_case(input logic [7:0] b);
      up_case = (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
   endfunction

   function automatic logic [7:0] low_case(input logic [7:0] b);
      low_case = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
   endfunction

endpackage

>>> src/lcrm_tracker.sv
// ----------------------------------------------------------------------------
// lcrm_tracker: run trackers
// Follows the letter run and both pair phases, raises mark ranges and keeps
// the saturating masked span count.
// ----------------------------------------------------------------------------
module lcrm_tracker #(
   parameter int POS_BITS = 20,
   parameter int HOMO_MIN = 5,
   parameter int PAIR_MIN = 5
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          accept,
   input  logic [7:0]                                    letter,
   input  logic                                          last,
   input  logic                                          hard_mask,
   output logic [POS_BITS-1:0]                           position,
   output logic [lcrm_pkg::NUM_MARKS-1:0]                mark_en,
   output logic [lcrm_pkg::NUM_MARKS-1:0][POS_BITS-1:0]  mark_lo,
   output logic [lcrm_pkg::NUM_MARKS-1:0][POS_BITS-1:0]  mark_hi,
   output logic [lcrm_pkg::COUNT_BITS-1:0]               count_next
);
   import lcrm_pkg::*;

   localparam int SUM_W = ((POS_BITS > COUNT_BITS) ? POS_BITS : COUNT_BITS) + 2;

   // x: phase of pairs starting at an index of the current parity (closing at q-1)
   // y: phase of the pair that this word completes (starting at q-1)
   logic [7:0]            letter_ff,       letter_in;
   logic                  letter_vld_ff,   letter_vld_in;
   logic [POS_BITS-1:0]   letter_start_ff, letter_start_in;
   logic [15:0]           pair_x_ff,       pair_x_in;
   logic [15:0]           pair_y_ff,       pair_y_in;
   logic                  pair_x_vld_ff,   pair_x_vld_in;
   logic                  pair_y_vld_ff,   pair_y_vld_in;
   logic [POS_BITS-1:0]   start_x_ff,      start_x_in;
   logic [POS_BITS-1:0]   start_y_ff,      start_y_in;
   logic [POS_BITS-1:0]   pos_ff,          pos_in;
   logic [COUNT_BITS-1:0] count_ff,        count_in;

   logic [POS_BITS-1:0] q, pair_off, pos_i, n_x, span_x, n_y, n_l;
   logic [15:0]         pair_new;
   logic                close_y, close_l, add_x, add_y, add_l;
   logic [SUM_W-1:0]    sum;

   always_comb begin
      q        = pos_ff;
      pos_i    = q - POS_BITS'(1);
      pair_off = hard_mask ? POS_BITS'(HARD_OFFSET) : POS_BITS'(SOFT_OFFSET);
      pair_new = {letter_ff, letter};

      // pair that ended at q-1: confirm it, or close it on the last word
      n_x    = q - POS_BITS'(2) - start_x_ff;
      span_x = q - start_x_ff;
      add_x  = pair_x_vld_ff && last && (n_x >= POS_BITS'(PAIR_MIN));
      mark_en[0] = pair_x_vld_ff &&
                   (last ? (n_x >= POS_BITS'(PAIR_MIN))
                         : ((n_x != '0) && (span_x >= POS_BITS'(PAIR_MIN))));
      mark_lo[0] = start_x_ff + pair_off;
      mark_hi[0] = last ? q - POS_BITS'(3) : q - POS_BITS'(1);

      // pair completed by this word
      n_y     = pos_i - start_y_ff;
      close_y = letter_vld_ff && pair_y_vld_ff && ((pair_new != pair_y_ff) || last);
      add_y   = close_y && (n_y >= POS_BITS'(PAIR_MIN));
      mark_en[1] = add_y;
      mark_lo[1] = start_y_ff + pair_off;
      mark_hi[1] = pos_i - POS_BITS'(1);

      // single letter run
      n_l     = q - letter_start_ff;
      close_l = letter_vld_ff && ((letter != letter_ff) || last);
      add_l   = close_l && (n_l >= POS_BITS'(HOMO_MIN));
      mark_en[2] = close_l ? add_l
                           : (letter_vld_ff && (n_l >= POS_BITS'(HOMO_MIN - 1)));
      mark_lo[2] = letter_start_ff + POS_BITS'(LETTER_OFFSET);
      mark_hi[2] = close_l ? q - POS_BITS'(1) : q;

      // saturating add of every span that qualifies on this word
      sum = SUM_W'(count_ff)
          + (add_x ? SUM_W'(n_x) : '0)
          + (add_y ? SUM_W'(n_y) : '0)
          + (add_l ? SUM_W'(n_l) : '0);
      count_next = (sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_BITS-1:0];

      // phases swap roles as the position advances
      pair_x_in     = letter_vld_ff ? pair_new : pair_y_ff;
      pair_x_vld_in = letter_vld_ff || pair_y_vld_ff;
      start_x_in    = (letter_vld_ff && (!pair_y_vld_ff || close_y)) ? pos_i : start_y_ff;
      pair_y_in     = pair_x_ff;
      pair_y_vld_in = pair_x_vld_ff;
      start_y_in    = start_x_ff;

      letter_in       = letter;
      letter_vld_in   = 1'b1;
      letter_start_in = (!letter_vld_ff || close_l) ? q : letter_start_ff;
      pos_in          = q + POS_BITS'(1);
      count_in        = count_next;
   end

   assign position = pos_ff;

   always_ff @(posedge clock) begin
      if (reset || (accept && last)) begin
         letter_ff       <= '0;
         letter_vld_ff   <= 1'b0;
         letter_start_ff <= '0;
         pair_x_ff       <= '0;
         pair_y_ff       <= '0;
         pair_x_vld_ff   <= 1'b0;
         pair_y_vld_ff   <= 1'b0;
         start_x_ff      <= '0;
         start_y_ff      <= '0;
         pos_ff          <= '0;
         count_ff        <= '0;
      end else if (accept) begin
         letter_ff       <= letter_in;
         letter_vld_ff   <= letter_vld_in;
         letter_start_ff <= letter_start_in;
         pair_x_ff       <= pair_x_in;
         pair_y_ff       <= pair_y_in;
         pair_x_vld_ff   <= pair_x_vld_in;
         pair_y_vld_ff   <= pair_y_vld_in;
         start_x_ff      <= start_x_in;
         start_y_ff      <= start_y_in;
         pos_ff          <= pos_in;
         count_ff        <= count_in;
      end
   end

endmodule

>>> src/lcrm_window.sv
// ----------------------------------------------------------------------------
// lcrm_window: delay window
// Holds pending bytes with their mask flags, applies mark ranges, emits the
// oldest byte and drains the whole window at the end of a sequence.
// ----------------------------------------------------------------------------
module lcrm_window #(
   parameter int WINDOW   = 8,
   parameter int POS_BITS = 20
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          accept,
   input  logic [7:0]                                    letter,
   input  logic                                          last,
   input  logic [POS_BITS-1:0]                           position,
   input  logic [lcrm_pkg::NUM_MARKS-1:0]                mark_en,
   input  logic [lcrm_pkg::NUM_MARKS-1:0][POS_BITS-1:0]  mark_lo,
   input  logic [lcrm_pkg::NUM_MARKS-1:0][POS_BITS-1:0]  mark_hi,
   input  logic [lcrm_pkg::COUNT_BITS-1:0]               count_final,
   input  logic                                          hard_mask,
   input  logic                                          nucleo_mode,
   input  logic                                          out_room,
   output logic                                          flushing,
   output logic                                          push_valid,
   output lcrm_pkg::out_word_type                        push_word
);
   import lcrm_pkg::*;

   localparam int SLOTS  = WINDOW + 1;
   localparam int FILL_W = $clog2(SLOTS + 1);

   logic [7:0]            byte_ff  [SLOTS];
   logic [7:0]            byte_in  [SLOTS];
   logic [SLOTS-1:0]      flag_ff,     flag_in;
   logic [FILL_W-1:0]     fill_ff,     fill_in;
   logic                  flushing_ff, flushing_in;
   logic [COUNT_BITS-1:0] total_ff,    total_in;

   logic [7:0]            byte_acc [SLOTS];
   logic [SLOTS-1:0]      flag_acc;
   logic [FILL_W-1:0]     fill_acc;
   logic [POS_BITS-1:0]   base;

   function automatic out_word_type emit(input logic [7:0] b, input logic flag,
                                         input logic hard, input logic nucleo,
                                         input logic last_word,
                                         input logic [COUNT_BITS-1:0] total);
      out_word_type w;
      w.char_out     = !flag ? b : (hard ? (nucleo ? FILL_NUCLEO : FILL_PROTEIN)
                                         : low_case(b));
      w.seq_end      = last_word;
      w.masked_count = last_word ? total : '0;
      emit = w;
   endfunction

   // window after the incoming word is placed and marked
   always_comb begin
      logic [POS_BITS-1:0] p;
      logic                hit;
      base = position - POS_BITS'(fill_ff);
      for (int k = 0; k < SLOTS; k++) begin
         p   = base + POS_BITS'(k);
         hit = 1'b0;
         for (int m = 0; m < NUM_MARKS; m++) begin
            if (mark_en[m] && ((p - mark_lo[m]) <= (mark_hi[m] - mark_lo[m]))) begin
               hit = 1'b1;
            end
         end
         byte_acc[k] = (FILL_W'(k) == fill_ff) ? letter : byte_ff[k];
         flag_acc[k] = ((FILL_W'(k) < fill_ff) && flag_ff[k]) ||
                       ((FILL_W'(k) <= fill_ff) && hit);
      end
      fill_acc = fill_ff + FILL_W'(1);
   end

   always_comb begin
      byte_in     = byte_ff;
      flag_in     = flag_ff;
      fill_in     = fill_ff;
      flushing_in = flushing_ff;
      total_in    = total_ff;
      push_valid  = 1'b0;
      push_word   = emit(byte_ff[0], flag_ff[0], hard_mask, nucleo_mode,
                         fill_ff == FILL_W'(1), total_ff);
      if (accept) begin
         if (last) begin
            // hold the whole window and start draining it
            byte_in     = byte_acc;
            flag_in     = flag_acc;
            fill_in     = fill_acc;
            flushing_in = 1'b1;
            total_in    = count_final;
         end else if (fill_acc > FILL_W'(WINDOW)) begin
            push_valid = 1'b1;
            push_word  = emit(byte_acc[0], flag_acc[0], hard_mask, nucleo_mode,
                              1'b0, '0);
            for (int k = 0; k < SLOTS - 1; k++) begin
               byte_in[k] = byte_acc[k + 1];
               flag_in[k] = flag_acc[k + 1];
            end
            byte_in[SLOTS-1] = byte_acc[SLOTS-1];
            flag_in[SLOTS-1] = 1'b0;
            fill_in          = FILL_W'(WINDOW);
         end else begin
            byte_in = byte_acc;
            flag_in = flag_acc;
            fill_in = fill_acc;
         end
      end else if (flushing_ff && out_room) begin
         // advance the drain by one word
         push_valid = 1'b1;
         for (int k = 0; k < SLOTS - 1; k++) begin
            byte_in[k] = byte_ff[k + 1];
            flag_in[k] = flag_ff[k + 1];
         end
         flag_in[SLOTS-1] = 1'b0;
         fill_in          = fill_ff - FILL_W'(1);
         if (fill_ff == FILL_W'(1)) begin
            flushing_in = 1'b0;
         end
      end
   end

   assign flushing = flushing_ff;

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      total_ff <= total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff     <= '0;
         fill_ff     <= '0;
         flushing_ff <= 1'b0;
      end else begin
         flag_ff     <= flag_in;
         fill_ff     <= fill_in;
         flushing_ff <= flushing_in;
      end
   end

endmodule

>>> src/lcrm_out_buf.sv
// ----------------------------------------------------------------------------
// lcrm_out_buf: result buffer
// Two-entry queue that parts the window from the result channel.
// ----------------------------------------------------------------------------
module lcrm_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  lcrm_pkg::out_word_type push_word,
   output logic                   room,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output lcrm_pkg::out_word_type rsp_word
);
   import lcrm_pkg::*;

   localparam int DEPTH = 2;

   out_word_type         mem_ff [DEPTH];
   logic [1:0]           count_ff, count_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 push, pop;

   always_comb begin
      room      = count_ff != 2'(DEPTH);
      rsp_valid = count_ff != 2'd0;
      rsp_word  = mem_ff[rd_ptr_ff];
      push      = push_valid && room;
      pop       = rsp_valid && rsp_ready;
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

endmodule

>>> src/low_complexity_run_masker.sv
// ----------------------------------------------------------------------------
// low_complexity_run_masker: masks low complexity runs in a byte stream
// Upper-cases each byte, delays it by WINDOW words and soft or hard masks
// letter runs and repeated pair runs; reports the masked span count.
// ----------------------------------------------------------------------------
// Output: a byte reaches rsp at the edge that takes the word WINDOW words after
//   it, or during the drain after its sequence's last word lands.
// Throughput: one word per cycle while the buffer has room; after a last word
//   input holds while the window (up to WINDOW+1 words) drains at that rate.
// Reset: synchronous; empties the window, trackers and result buffer, sets
//   hard_mask to 0 and nucleo_mode to 1.
module low_complexity_run_masker #(
   parameter int WINDOW   = lcrm_pkg::WINDOW_DEF,
   parameter int POS_BITS = lcrm_pkg::POS_BITS_DEF,
   parameter int HOMO_MIN = lcrm_pkg::HOMO_MIN_DEF,
   parameter int PAIR_MIN = lcrm_pkg::PAIR_MIN_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_char_in,
   input  logic                                req_is_last,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_char_out,
   output logic                                rsp_seq_end,
   output logic [lcrm_pkg::COUNT_BITS-1:0]     rsp_masked_count,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [lcrm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lcrm_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import lcrm_pkg::*;

   logic                                hard_mask_ff, hard_mask_in;
   logic                                nucleo_mode_ff, nucleo_mode_in;

   logic                                accept;
   logic [7:0]                          letter;
   logic [POS_BITS-1:0]                 position;
   logic [NUM_MARKS-1:0]                mark_en;
   logic [NUM_MARKS-1:0][POS_BITS-1:0]  mark_lo;
   logic [NUM_MARKS-1:0][POS_BITS-1:0]  mark_hi;
   logic [COUNT_BITS-1:0]               count_next;
   logic                                flushing;
   logic                                out_room;
   logic                                push_valid;
   out_word_type                        push_word;
   out_word_type                        rsp_word;

   // configuration registers: the user must write only while the block is idle
   always_comb begin
      hard_mask_in   = hard_mask_ff;
      nucleo_mode_in = nucleo_mode_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_HARD_MASK:   hard_mask_in   = csr_wdata[0];
            CSR_NUCLEO_MODE: nucleo_mode_in = csr_wdata[0];
            default: begin
               hard_mask_in   = hard_mask_ff;
               nucleo_mode_in = nucleo_mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hard_mask_ff   <= 1'b0;
         nucleo_mode_ff <= 1'b1;
      end else begin
         hard_mask_ff   <= hard_mask_in;
         nucleo_mode_ff <= nucleo_mode_in;
      end
   end

   // take a word whenever the window is not draining and the buffer has a slot;
   // a non-last word pushes at most one result, so one free slot is enough
   assign req_ready = !flushing && out_room;
   assign accept    = req_valid && req_ready;
   assign letter    = up_case(req_char_in);

   // run trackers: decide which window positions to flag on this word
   lcrm_tracker #(
      .POS_BITS (POS_BITS),
      .HOMO_MIN (HOMO_MIN),
      .PAIR_MIN (PAIR_MIN)
   ) u_tracker (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .letter     (letter),
      .last       (req_is_last),
      .hard_mask  (hard_mask_ff),
      .position   (position),
      .mark_en    (mark_en),
      .mark_lo    (mark_lo),
      .mark_hi    (mark_hi),
      .count_next (count_next)
   );

   // delay window: apply the flags, release the oldest byte, drain at the end
   lcrm_window #(
      .WINDOW   (WINDOW),
      .POS_BITS (POS_BITS)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .letter      (letter),
      .last        (req_is_last),
      .position    (position),
      .mark_en     (mark_en),
      .mark_lo     (mark_lo),
      .mark_hi     (mark_hi),
      .count_final (count_next),
      .hard_mask   (hard_mask_ff),
      .nucleo_mode (nucleo_mode_ff),
      .out_room    (out_room),
      .flushing    (flushing),
      .push_valid  (push_valid),
      .push_word   (push_word)
   );

   // result buffer: lets the input keep going while a word waits on rsp
   lcrm_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_word  (push_word),
      .room       (out_room),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

   assign rsp_char_out     = rsp_word.char_out;
   assign rsp_seq_end      = rsp_word.seq_end;
   assign rsp_masked_count = rsp_word.masked_count;

endmodule

>>> src/lcrm_checker.sv
// ----------------------------------------------------------------------------
// lcrm_checker: port checks for the low complexity run masker
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module lcrm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            req_is_last,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [7:0]                      rsp_char_out,
   input logic                            rsp_seq_end,
   input logic [lcrm_pkg::COUNT_BITS-1:0] rsp_masked_count
);
   import lcrm_pkg::*;

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_out) &&
                                  $stable(rsp_seq_end) && $stable(rsp_masked_count))
      else $error("stalled result word changed");

   // the count travels only on the closing word of a sequence
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_seq_end |-> rsp_masked_count == '0)
      else $error("masked count on a word that does not end a sequence");

   // a last word starts the drain, so input is held on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_is_last |=> !req_ready)
      else $error("input taken while the window drains");

   // reset leaves no result pending
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind low_complexity_run_masker lcrm_checker u_lcrm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_is_last      (req_is_last),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_char_out     (rsp_char_out),
   .rsp_seq_end      (rsp_seq_end),
   .rsp_masked_count (rsp_masked_count)
);

>>> tb/low_complexity_run_masker_test.sv
// ----------------------------------------------------------------------------
// low_complexity_run_masker_test: self-checking bench for the run masker
// Streams directed and random sequences through the masker while both sides
// pause and stall at random. A behavioural copy of the masking rules predicts
// every output word, and each output word is compared field by field.
// ----------------------------------------------------------------------------
module low_complexity_run_masker_test;
   import lcrm_pkg::*;

   localparam int WIN         = WINDOW_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE      = WINDOW_DEF + 4;
   localparam int PHASES      = 5;
   localparam int PHASE_WORDS = 40;

   typedef bit [POS_BITS_DEF-1:0] pos_type;

   typedef struct {
      bit [7:0] ch;
      bit       last;
   } base_word_type;

   // ---------------------------------------------------------------------
   // DUT signals: every input holds a known value from time zero
   // ---------------------------------------------------------------------
   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_ready;
   logic [7:0]                req_char_in = 8'h00;
   logic                      req_is_last = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready   = 1'b0;
   logic [7:0]                rsp_char_out;
   logic                      rsp_seq_end;
   logic [COUNT_BITS-1:0]     rsp_masked_count;
   logic                      csr_wr_en   = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index   = CSR_HARD_MASK;
   logic [CSR_DATA_BITS-1:0]  csr_wdata   = '0;

   // ---------------------------------------------------------------------
   // Bench bookkeeping
   // ---------------------------------------------------------------------
   base_word_type pending_words [$];   // words waiting to be offered
   out_word_type  masked_words  [$];   // predicted output words, oldest first
   int words_offered  = 0;
   int words_accepted = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;
   int req_idle_pct   = 0;
   int rsp_stall_pct  = 0;

   // per-phase idling and register settings
   int phase_idle   [PHASES] = '{0, 75, 0, 32, 0};
   int phase_stall  [PHASES] = '{0, 0, 75, 32, 0};
   bit phase_hard   [PHASES] = '{0, 1, 1, 0, 1};
   bit phase_nucleo [PHASES] = '{1, 1, 0, 0, 1};

   // ---------------------------------------------------------------------
   // Predictor state: the delay window, the run trackers and the registers
   // ---------------------------------------------------------------------
   bit [7:0]  win_byte [0:WIN];
   bit        win_flag [0:WIN];
   int        win_fill;
   bit        letter_seen;
   bit [7:0]  last_letter;
   pos_type   letter_start;
   bit        pair_seen  [2];
   bit [15:0] pair_value [2];
   pos_type   pair_start [2];
   pos_type   seq_pos;
   int unsigned span_total;
   bit        cfg_hard   = 1'b0;
   bit        cfg_nucleo = 1'b1;

   low_complexity_run_masker DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_in      (req_char_in),
      .req_is_last      (req_is_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_char_out     (rsp_char_out),
      .rsp_seq_end      (rsp_seq_end),
      .rsp_masked_count (rsp_masked_count),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Masking predictor
   // ---------------------------------------------------------------------
   function automatic bit [7:0] upper_letter(input bit [7:0] b);
      return (b >= "a" && b <= "z") ? b - 8'd32 : b;
   endfunction

   function automatic bit [7:0] lower_letter(input bit [7:0] b);
      return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
   endfunction

   function automatic void clear_sequence_state();
      for (int k = 0; k <= WIN; k++) begin
         win_byte[k] = 8'h00;
         win_flag[k] = 1'b0;
      end
      win_fill     = 0;
      letter_seen  = 1'b0;
      last_letter  = 8'h00;
      letter_start = '0;
      for (int p = 0; p < 2; p++) begin
         pair_seen[p]  = 1'b0;
         pair_value[p] = 16'h0000;
         pair_start[p] = '0;
      end
      seq_pos    = '0;
      span_total = 0;
   endfunction

   function automatic void add_span(input pos_type n);
      span_total = (span_total + 32'(n) > 32'(COUNT_MAX)) ? 32'(COUNT_MAX)
                                                          : span_total + 32'(n);
   endfunction

   // flag every windowed position in [a, b]; q is the newest position
   function automatic void flag_span(input pos_type a, input pos_type b, input pos_type q);
      pos_type len;
      pos_type p;
      pos_type off;
      len = b - a;
      for (int k = 0; k < win_fill; k++) begin
         p   = q - pos_type'(win_fill - 1 - k);
         off = p - a;
         if (off <= len)
            win_flag[k] = 1'b1;
      end
   endfunction

   // soft or hard choice and fill letter are taken when the byte leaves
   function automatic bit [7:0] window_byte_out(input int k);
      if (!win_flag[k])
         return win_byte[k];
      if (cfg_hard)
         return cfg_nucleo ? FILL_NUCLEO : FILL_PROTEIN;
      return lower_letter(win_byte[k]);
   endfunction

   task automatic predict_masking(input bit [7:0] ch_raw, input bit last);
      bit [7:0]     u;
      bit [15:0]    pair;
      pos_type      q;
      pos_type      s;
      pos_type      n;
      pos_type      d;
      pos_type      i;
      pos_type      pair_off;
      int           ph;
      out_word_type w;
      u        = upper_letter(ch_raw);
      q        = seq_pos;
      pair_off = cfg_hard ? pos_type'(HARD_OFFSET) : pos_type'(SOFT_OFFSET);

      win_byte[win_fill] = u;
      win_flag[win_fill] = 1'b0;
      win_fill++;

      // pair run of the other phase that ended at q-1: confirm or close it
      ph = int'(q[0]);
      if (pair_seen[ph]) begin
         s = pair_start[ph];
         n = q - pos_type'(2) - s;
         if (last) begin
            if (n >= PAIR_MIN_DEF) begin
               add_span(n);
               flag_span(s + pair_off, q - pos_type'(3), q);
            end
            pair_start[ph] = q - pos_type'(2);
         end else begin
            d = q - s;
            if (n != 0 && d >= PAIR_MIN_DEF)
               flag_span(s + pair_off, q - pos_type'(1), q);
         end
      end

      // pair completed by this byte, starting at q-1
      if (letter_seen) begin
         i    = q - pos_type'(1);
         ph   = int'(i[0]);
         pair = {last_letter, u};
         if (!pair_seen[ph]) begin
            pair_start[ph] = i;
         end else if (pair != pair_value[ph] || last) begin
            s = pair_start[ph];
            n = i - s;
            if (n >= PAIR_MIN_DEF) begin
               add_span(n);
               flag_span(s + pair_off, i - pos_type'(1), q);
            end
            pair_start[ph] = i;
         end
         pair_seen[ph]  = 1'b1;
         pair_value[ph] = pair;
      end

      // single letter runs
      if (!letter_seen) begin
         letter_start = q;
      end else if (u != last_letter || last) begin
         n = q - letter_start;
         if (n >= HOMO_MIN_DEF) begin
            add_span(n);
            flag_span(letter_start + pos_type'(LETTER_OFFSET), q - pos_type'(1), q);
         end
         letter_start = q;
      end else begin
         d = q - letter_start;
         if (int'(d) + 1 >= HOMO_MIN_DEF)
            flag_span(letter_start + pos_type'(LETTER_OFFSET), q, q);
      end
      letter_seen = 1'b1;
      last_letter = u;

      if (last) begin
         // flush the whole window; only the final word carries the count
         for (int k = 0; k < win_fill; k++) begin
            w.char_out     = window_byte_out(k);
            w.seq_end      = (k == win_fill - 1);
            w.masked_count = w.seq_end ? span_total[COUNT_BITS-1:0] : '0;
            masked_words.push_back(w);
         end
         clear_sequence_state();
      end else begin
         if (win_fill > WIN) begin
            w.char_out     = window_byte_out(0);
            w.seq_end      = 1'b0;
            w.masked_count = '0;
            masked_words.push_back(w);
            for (int k = 0; k < win_fill - 1; k++) begin
               win_byte[k] = win_byte[k+1];
               win_flag[k] = win_flag[k+1];
            end
            win_fill--;
         end
         seq_pos = q + pos_type'(1);
      end
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic bit [7:0] random_letter();
      bit [7:0] bases [4] = '{"A", "C", "G", "T"};
      if ($urandom_range(99) < 60)
         return bases[$urandom_range(3)];
      return 8'h41 + 8'($urandom_range(25));
   endfunction

   function automatic bit [7:0] mix_case(input bit [7:0] c);
      return ($urandom_range(1) == 1) ? lower_letter(c) : c;
   endfunction

   task automatic queue_text(input string s, input bit close);
      base_word_type item;
      for (int k = 0; k < s.len(); k++) begin
         item.ch   = s[k];
         item.last = close && (k == s.len() - 1);
         pending_words.push_back(item);
      end
   endtask

   task automatic queue_single(input bit [7:0] ch);
      base_word_type item;
      item.ch   = ch;
      item.last = 1'b1;
      pending_words.push_back(item);
   endtask

   // mostly letter runs and pair repeats, some plain bases and raw noise
   task automatic queue_random_sequence(input int len);
      bit [7:0]      seq_bytes [$];
      bit [7:0]      a;
      bit [7:0]      b;
      int            kind;
      base_word_type item;
      while (seq_bytes.size() < len) begin
         kind = $urandom_range(99);
         if (kind < 35) begin
            a = random_letter();
            repeat ($urandom_range(3, 14)) seq_bytes.push_back(mix_case(a));
         end else if (kind < 65) begin
            a = random_letter();
            b = random_letter();
            repeat ($urandom_range(2, 10)) begin
               seq_bytes.push_back(mix_case(a));
               seq_bytes.push_back(mix_case(b));
            end
         end else if (kind < 90) begin
            repeat ($urandom_range(1, 6)) seq_bytes.push_back(mix_case(random_letter()));
         end else if (kind < 95) begin
            repeat ($urandom_range(1, 3)) seq_bytes.push_back(8'($urandom_range(255)));
         end else begin
            a = 8'($urandom_range(255));
            repeat ($urandom_range(1, 7)) seq_bytes.push_back(a);
         end
      end
      for (int k = 0; k < len; k++) begin
         item.ch   = seq_bytes[k];
         item.last = (k == len - 1);
         pending_words.push_back(item);
      end
   endtask

   // hold until every word is in, every output word is out and the window
   // logic has had time to finish
   task automatic settle();
      while (pending_words.size() != 0 || words_offered != words_accepted)
         @(posedge clock);
      while (masked_words.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Driver: offer the next pending word at the falling edge, hold it until
   // taken; the receiver side stalls at random on the same edge
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : drive_words
      base_word_type item;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         if (words_offered == words_accepted) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
               item = pending_words.pop_front();
               req_char_in <= item.ch;
               req_is_last <= item.last;
               req_valid   <= 1'b1;
               words_offered++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on accepted input words, check accepted output words,
   // track register writes, and guard the run length
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : watch_words
      out_word_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("low_complexity_run_masker_test failed");
         $finish;
      end
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_masking(req_char_in, req_is_last);
            words_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (masked_words.size() == 0) begin
               mismatch_count++;
               $display("%0t: output word with none expected, got %02h/%0d/%0d",
                        $time, rsp_char_out, rsp_seq_end, rsp_masked_count);
            end else begin
               want = masked_words.pop_front();
               if (rsp_char_out !== want.char_out) begin
                  mismatch_count++;
                  $display("%0t: char_out expected %02h, got %02h",
                           $time, want.char_out, rsp_char_out);
               end
               if (rsp_seq_end !== want.seq_end) begin
                  mismatch_count++;
                  $display("%0t: seq_end expected %0d, got %0d",
                           $time, want.seq_end, rsp_seq_end);
               end
               if (rsp_masked_count !== want.masked_count) begin
                  mismatch_count++;
                  $display("%0t: masked_count expected %0d, got %0d",
                           $time, want.masked_count, rsp_masked_count);
               end
            end
         end
         // registers only change while idle, so update after predicting
         if (csr_wr_en) begin
            if (csr_index == CSR_HARD_MASK)
               cfg_hard = csr_wdata[0];
            else if (csr_index == CSR_NUCLEO_MODE)
               cfg_nucleo = csr_wdata[0];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer: directed sequences, then random phases with their own
   // idling and register settings
   // ---------------------------------------------------------------------
   initial begin : run_phases
      int len;
      int phase_words;
      clear_sequence_state();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // one-byte sequences: only upper-cased
      queue_single("z");
      queue_single(8'hFF);
      // letter run closed by the last byte, which is left out of it
      queue_text("cccccc", 1'b1);
      // pair repeat under soft masking, then a short one under hard masking
      queue_text("acacacac", 1'b1);
      settle();
      write_csr(CSR_HARD_MASK, 1'b1);
      queue_text("acacT", 1'b1);

      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         write_csr(CSR_HARD_MASK, phase_hard[ph]);
         write_csr(CSR_NUCLEO_MODE, phase_nucleo[ph]);
         req_idle_pct  = phase_idle[ph];
         rsp_stall_pct = phase_stall[ph];
         phase_words   = 0;
         while (phase_words < PHASE_WORDS) begin
            len = $urandom_range(99);
            if (len < 10)
               len = 1;
            else if (len < 75)
               len = $urandom_range(2, 30);
            else
               len = $urandom_range(31, 70);
            queue_random_sequence(len);
            phase_words += len;
         end
      end
      settle();

      if (mismatch_count == 0)
         $display("low_complexity_run_masker_test passed");
      else
         $display("low_complexity_run_masker_test failed");
      $finish;
   end

endmodule
